[design/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg: shared types, constants and the tanh table for the soft clipper
// Holds the cell payload structs of the three cell chains, the register index
// codes of the configuration port and the elaboration-time tanh table builder.
// ----------------------------------------------------------------------------
package csc_pkg;

  // tanh table: entries 0..TANH_DEPTH cover x in [0, 4]
  localparam int TANH_DEPTH = 256;
  localparam int IDX_W      = $clog2(TANH_DEPTH);
  localparam int TAB_AW     = $clog2(TANH_DEPTH + 1);
  // table position: index plus 16-bit fraction
  localparam int POS_W      = IDX_W + 16;
  // dividend of the position division: d * DEPTH * 2^14
  localparam int NUM_W      = 16 + IDX_W + 15;
  localparam logic [IDX_W+14:0] POS_SCALE = (IDX_W + 15)'(TANH_DEPTH * 16384);

  localparam int SQRT_STEPS  = 16;
  localparam int SCALE_STEPS = 16;

  localparam logic [15:0] THRESHOLD_RESET = 16'd16384;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_CLIP_ENABLE = 1'b0,
    CFG_THRESHOLD   = 1'b1
  } cfg_idx_t;

  // sample context carried along every stage
  typedef struct packed {
    logic               valid;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic        [15:0] m;
  } ctx_t;

  // square root cell: one root bit per cell
  typedef struct packed {
    ctx_t        ctx;
    logic [19:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sqrt_cell_t;

  // table position cell: one quotient bit of d*DEPTH*2^14 / span
  typedef struct packed {
    ctx_t             ctx;
    logic             active;
    logic             sat;
    logic [16:0]      rem;
    logic [POS_W-1:0] low;
    logic [POS_W-1:0] q;
  } pos_cell_t;

  // scaling cell: one quotient bit of both parts, divisor is the magnitude
  typedef struct packed {
    ctx_t        ctx;
    logic        clipped;
    logic [17:0] rem_re;
    logic [15:0] low_re;
    logic [15:0] q_re;
    logic [17:0] rem_im;
    logic [15:0] low_im;
    logic [15:0] q_im;
  } scale_cell_t;

  typedef logic [15:0] tanh_tab_t [TANH_DEPTH+1];

  // restoring 64-bit division, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      q = {q[62:0], 1'b0};
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // tanh(4k/DEPTH) in Q0.15, exp summed as a Q32 Taylor series
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t         tab;
    longint unsigned   one;
    longint unsigned   sum;
    longint unsigned   term;
    longint unsigned   num;
    longint unsigned   dv;
    longint unsigned   den;
    longint unsigned   t;
    one = 64'd1 << 32;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      sum  = one;
      term = one;
      num  = 64'(8 * k);
      for (int n = 1; n < 64; n++) begin
        dv   = 64'(TANH_DEPTH) * 64'(n);
        term = udiv64(term * num, dv);
        sum  = sum + term;
      end
      den = sum + one;
      t   = udiv64(((sum - one) << 15) + (den >> 1), den);
      if (t > 64'd32768) t = 64'd32768;
      tab[k] = t[15:0];
    end
    return tab;
  endfunction

endpackage

[design/csc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// csc_sqrt_cell: one step of the integer square root
// Brings in two radicand bits, tries the next root bit and registers the
// partial root and remainder for the next cell.
// ----------------------------------------------------------------------------
module csc_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  csc_pkg::sqrt_cell_t d_in,
  output csc_pkg::sqrt_cell_t d_out
);
  import csc_pkg::*;

  logic [19:0] rem_sh;
  logic [19:0] trial;
  sqrt_cell_t  cell_next;

  // trial subtract of (4*root + 1)
  always_comb begin
    rem_sh    = {d_in.rem[17:0], d_in.rad[31:30]};
    trial     = {2'b00, d_in.root, 2'b01};
    cell_next = d_in;
    cell_next.rad = {d_in.rad[29:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_next.rem  = rem_sh - trial;
      cell_next.root = {d_in.root[14:0], 1'b1};
    end else begin
      cell_next.rem  = rem_sh;
      cell_next.root = {d_in.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.ctx.valid <= 1'b0;
    end else if (en) begin
      d_out <= cell_next;
    end
  end

endmodule

[design/csc_pos_cell.sv]
// ----------------------------------------------------------------------------
// csc_pos_cell: one quotient bit of the tanh table position
// Restoring division step by the span, one dividend bit shifted in per cell.
// ----------------------------------------------------------------------------
module csc_pos_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [14:0]        span,
  input  csc_pkg::pos_cell_t d_in,
  output csc_pkg::pos_cell_t d_out
);
  import csc_pkg::*;

  logic [16:0] rem_sh;
  pos_cell_t   cell_next;

  always_comb begin
    rem_sh    = {d_in.rem[15:0], d_in.low[POS_W-1]};
    cell_next = d_in;
    cell_next.low = {d_in.low[POS_W-2:0], 1'b0};
    if (rem_sh >= {2'b00, span}) begin
      cell_next.rem = rem_sh - {2'b00, span};
      cell_next.q   = {d_in.q[POS_W-2:0], 1'b1};
    end else begin
      cell_next.rem = rem_sh;
      cell_next.q   = {d_in.q[POS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.ctx.valid <= 1'b0;
    end else if (en) begin
      d_out <= cell_next;
    end
  end

endmodule

[design/csc_scale_cell.sv]
// ----------------------------------------------------------------------------
// csc_scale_cell: one quotient bit of the I and Q rescaling
// Two restoring division steps side by side, both dividing by the magnitude.
// ----------------------------------------------------------------------------
module csc_scale_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  csc_pkg::scale_cell_t d_in,
  output csc_pkg::scale_cell_t d_out
);
  import csc_pkg::*;

  logic [17:0] div;
  logic [17:0] sh_re;
  logic [17:0] sh_im;
  scale_cell_t cell_next;

  always_comb begin
    div       = {2'b00, d_in.ctx.m};
    sh_re     = {d_in.rem_re[16:0], d_in.low_re[15]};
    sh_im     = {d_in.rem_im[16:0], d_in.low_im[15]};
    cell_next = d_in;
    cell_next.low_re = {d_in.low_re[14:0], 1'b0};
    cell_next.low_im = {d_in.low_im[14:0], 1'b0};
    // in-phase part
    if (sh_re >= div) begin
      cell_next.rem_re = sh_re - div;
      cell_next.q_re   = {d_in.q_re[14:0], 1'b1};
    end else begin
      cell_next.rem_re = sh_re;
      cell_next.q_re   = {d_in.q_re[14:0], 1'b0};
    end
    // quadrature part
    if (sh_im >= div) begin
      cell_next.rem_im = sh_im - div;
      cell_next.q_im   = {d_in.q_im[14:0], 1'b1};
    end else begin
      cell_next.rem_im = sh_im;
      cell_next.q_im   = {d_in.q_im[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.ctx.valid <= 1'b0;
    end else if (en) begin
      d_out <= cell_next;
    end
  end

endmodule

[design/complex_soft_clipper.sv]
// ----------------------------------------------------------------------------
// complex_soft_clipper: tanh-knee soft clipper on complex sample magnitude
// Magnitude by a square root cell chain, knee compression through an
// interpolated tanh table, then I/Q rescaling through a division cell chain.
// ----------------------------------------------------------------------------
// Takes one complex sample per clock while in_stall is low and returns one
// result per sample, in order. The pipeline is the input and square
// registers, 16 square-root cells, one knee stage, one table-position cell
// per quotient bit (log2(depth) + 16), four stages of interpolation and
// new-magnitude arithmetic, 16 rescaling cells and the output register. A
// two-entry output buffer lets the pipeline run while a result waits;
// in_stall rises only once both entries are full. Write the configuration
// registers only while the block is empty.
module complex_soft_clipper (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_real,
  input  logic signed [15:0] sample_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_real,
  output logic signed [15:0] out_imag,
  output logic               was_clipped
);
  import csc_pkg::*;

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

  logic        clip_enable;
  logic [15:0] threshold;
  logic [17:0] thr3;
  logic [15:0] knee;
  logic [14:0] span;
  logic        en;
  logic        skid_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b1;
      threshold   <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLIP_ENABLE: clip_enable <= cfg_data[0];
        CFG_THRESHOLD:   threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // knee = floor(3T/4), span = T - knee
  always_comb begin
    thr3 = {2'b00, threshold} + {1'b0, threshold, 1'b0};
    knee = thr3[17:2];
    span = 15'(threshold - knee);
  end

  assign en       = ~skid_full;
  assign in_stall = skid_full;

  // input register
  ctx_t a_ctx;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctx.valid <= 1'b0;
    end else if (en) begin
      a_ctx.valid <= in_valid;
      a_ctx.re    <= sample_real;
      a_ctx.im    <= sample_imag;
      a_ctx.m     <= '0;
    end
  end

  // squares
  ctx_t               b_ctx;
  logic signed [31:0] sq_re_full;
  logic signed [31:0] sq_im_full;
  logic        [30:0] b_sq_re;
  logic        [30:0] b_sq_im;

  assign sq_re_full = a_ctx.re * a_ctx.re;
  assign sq_im_full = a_ctx.im * a_ctx.im;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctx.valid <= 1'b0;
    end else if (en) begin
      b_ctx   <= a_ctx;
      b_sq_re <= sq_re_full[30:0];
      b_sq_im <= sq_im_full[30:0];
    end
  end

  // square root chain
  sqrt_cell_t sq_head;
  sqrt_cell_t sq [SQRT_STEPS+1];

  always_comb begin
    sq_head.ctx  = b_ctx;
    sq_head.rem  = '0;
    sq_head.root = '0;
    sq_head.rad  = 32'(b_sq_re) + 32'(b_sq_im);
  end
  assign sq[0] = sq_head;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    csc_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sq[g]),
      .d_out (sq[g+1])
    );
  end

  // knee test
  ctx_t        d_ctx;
  logic [15:0] d_delta;
  logic        d_active;
  logic        d_sat;
  logic [15:0] mag;
  logic [15:0] delta;

  assign mag   = sq[SQRT_STEPS].root;
  assign delta = mag - knee;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctx.valid <= 1'b0;
    end else if (en) begin
      d_ctx.valid <= sq[SQRT_STEPS].ctx.valid;
      d_ctx.re    <= sq[SQRT_STEPS].ctx.re;
      d_ctx.im    <= sq[SQRT_STEPS].ctx.im;
      d_ctx.m     <= mag;
      d_delta     <= delta;
      d_active    <= clip_enable && (threshold != 16'd0) && (mag != 16'd0) && (mag > knee);
      // past the end of the table when d >= 4*span
      d_sat       <= {1'b0, delta} >= {span, 2'b00};
    end
  end

  // table position chain
  pos_cell_t        pc_head;
  pos_cell_t        pc [POS_W+1];
  logic [NUM_W-1:0] n_full;

  always_comb begin
    n_full         = NUM_W'(d_delta) * NUM_W'(POS_SCALE);
    pc_head.ctx    = d_ctx;
    pc_head.active = d_active;
    pc_head.sat    = d_sat;
    pc_head.rem    = 17'(n_full[NUM_W-1:POS_W]);
    pc_head.low    = n_full[POS_W-1:0];
    pc_head.q      = '0;
  end
  assign pc[0] = pc_head;

  for (genvar g = 0; g < POS_W; g++) begin : g_pos
    csc_pos_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .span  (span),
      .d_in  (pc[g]),
      .d_out (pc[g+1])
    );
  end

  // table lookup
  ctx_t              i_ctx;
  logic              i_active;
  logic [15:0]       i_lo;
  logic [15:0]       i_diff;
  logic [15:0]       i_frac;
  logic [TAB_AW-1:0] idx_ext;
  logic [15:0]       tab_lo;
  logic [15:0]       tab_hi;
  logic [15:0]       tab_diff;

  always_comb begin
    idx_ext = TAB_AW'(pc[POS_W].q[POS_W-1:16]);
    tab_hi  = '0;
    if (pc[POS_W].sat || idx_ext >= TAB_AW'(TANH_DEPTH)) begin
      tab_lo   = TANH_TAB[TANH_DEPTH];
      tab_diff = '0;
    end else begin
      tab_lo   = TANH_TAB[idx_ext];
      tab_hi   = TANH_TAB[idx_ext + TAB_AW'(1)];
      tab_diff = (tab_hi >= tab_lo) ? tab_hi - tab_lo : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_ctx.valid <= 1'b0;
    end else if (en) begin
      i_ctx    <= pc[POS_W].ctx;
      i_active <= pc[POS_W].active;
      i_lo     <= tab_lo;
      i_diff   <= tab_diff;
      i_frac   <= pc[POS_W].q[15:0];
    end
  end

  // interpolation product
  ctx_t        j_ctx;
  logic        j_active;
  logic [15:0] j_lo;
  logic [31:0] j_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_ctx.valid <= 1'b0;
    end else if (en) begin
      j_ctx    <= i_ctx;
      j_active <= i_active;
      j_lo     <= i_lo;
      j_prod   <= 32'(i_diff) * 32'(i_frac);
    end
  end

  // interpolated tanh, times span
  ctx_t        k_ctx;
  logic        k_active;
  logic [30:0] k_sprod;
  logic [32:0] interp_rnd;
  logic [15:0] tanh_val;

  always_comb begin
    interp_rnd = 33'(j_prod) + 33'd32768;
    tanh_val   = j_lo + 16'(interp_rnd >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_ctx.valid <= 1'b0;
    end else if (en) begin
      k_ctx    <= j_ctx;
      k_active <= j_active;
      k_sprod  <= 31'(span) * 31'(tanh_val);
    end
  end

  // new magnitude and clip decision
  ctx_t        l_ctx;
  logic        l_clipped;
  logic [15:0] l_nm;
  logic [31:0] nm_rnd;
  logic [16:0] new_mag;

  always_comb begin
    nm_rnd  = 32'(k_sprod) + 32'd16384;
    new_mag = 17'(knee) + 17'(nm_rnd >> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_ctx.valid <= 1'b0;
    end else if (en) begin
      l_ctx     <= k_ctx;
      l_clipped <= k_active && (new_mag < 17'(k_ctx.m));
      l_nm      <= new_mag[15:0];
    end
  end

  // rescaling chain
  scale_cell_t sc_head;
  scale_cell_t sc [SCALE_STEPS+1];
  logic [15:0] abs_re;
  logic [15:0] abs_im;
  logic [32:0] num_re;
  logic [32:0] num_im;

  always_comb begin
    abs_re = l_ctx.re[15] ? 16'(~l_ctx.re + 16'sd1) : 16'(l_ctx.re);
    abs_im = l_ctx.im[15] ? 16'(~l_ctx.im + 16'sd1) : 16'(l_ctx.im);
    // rounding to nearest: add half the magnitude
    num_re = 33'(abs_re) * 33'(l_nm) + 33'(l_ctx.m >> 1);
    num_im = 33'(abs_im) * 33'(l_nm) + 33'(l_ctx.m >> 1);
    sc_head.ctx     = l_ctx;
    sc_head.clipped = l_clipped;
    sc_head.rem_re  = 18'(num_re[32:16]);
    sc_head.low_re  = num_re[15:0];
    sc_head.q_re    = '0;
    sc_head.rem_im  = 18'(num_im[32:16]);
    sc_head.low_im  = num_im[15:0];
    sc_head.q_im    = '0;
  end
  assign sc[0] = sc_head;

  for (genvar g = 0; g < SCALE_STEPS; g++) begin : g_scale
    csc_scale_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sc[g]),
      .d_out (sc[g+1])
    );
  end

  // result selection with sign restored
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic               res_clipped;
  logic               res_valid;

  always_comb begin
    res_valid   = sc[SCALE_STEPS].ctx.valid;
    res_clipped = sc[SCALE_STEPS].clipped;
    if (res_clipped) begin
      res_re = sc[SCALE_STEPS].ctx.re[15] ? -$signed(sc[SCALE_STEPS].q_re)
                                          : $signed(sc[SCALE_STEPS].q_re);
      res_im = sc[SCALE_STEPS].ctx.im[15] ? -$signed(sc[SCALE_STEPS].q_im)
                                          : $signed(sc[SCALE_STEPS].q_im);
    end else begin
      res_re = sc[SCALE_STEPS].ctx.re;
      res_im = sc[SCALE_STEPS].ctx.im;
    end
  end

  // output register and skid entry
  logic signed [15:0] skid_re;
  logic signed [15:0] skid_im;
  logic               skid_clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) skid_full <= 1'b0;
    end else if (res_valid) begin
      if (out_valid && out_stall) skid_full <= 1'b1;
      else                        out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!out_stall) begin
        out_real    <= skid_re;
        out_imag    <= skid_im;
        was_clipped <= skid_clipped;
      end
    end else if (res_valid) begin
      if (out_valid && out_stall) begin
        skid_re      <= res_re;
        skid_im      <= res_im;
        skid_clipped <= res_clipped;
      end else begin
        out_real    <= res_re;
        out_imag    <= res_im;
        was_clipped <= res_clipped;
      end
    end
  end

  // checks
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid entry filled without a held result");

  a_skid_valid: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry full with output register empty");

  a_clip_cfg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_clipped) |-> (clip_enable && threshold != 16'd0))
    else $error("clipped result while clipping disabled");

endmodule

[tb/sv/csc_checker.sv]
// ----------------------------------------------------------------------------
// csc_checker: result predictor and scoreboard for the soft clipper
// Watches both channels and the configuration port, computes the expected
// clipped sample for every input transfer and compares it, field by field,
// with each output transfer in order.
// ----------------------------------------------------------------------------
module csc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] sample_real,
  input  logic signed [15:0] sample_imag,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_real,
  input  logic signed [15:0] out_imag,
  input  logic               was_clipped,
  output int                 fail_count,
  output int                 pending
);
  import csc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               clipped;
  } clip_result_t;

  logic [15:0]  tanh_lut [TANH_DEPTH+1];
  logic         enable_q;
  logic [15:0]  thresh_q;
  clip_result_t expected_q[$];

  // own tanh table, exp as a Q32 Taylor sum
  initial begin
    longint unsigned one, sum, term, den, t;
    one = 64'd1 << 32;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      sum  = one;
      term = one;
      for (int n = 1; n < 64; n++) begin
        term = term * longint'(8 * k) / (longint'(TANH_DEPTH) * n);
        sum += term;
      end
      den = sum + one;
      t   = (((sum - one) << 15) + den / 2) / den;
      if (t > 32768) t = 32768;
      tanh_lut[k] = t[15:0];
    end
  end

  function automatic longint rescale(longint v, longint nm, longint m);
    longint a;
    a = (v < 0) ? -v : v;
    a = (a * nm + m / 2) / m;
    return (v < 0) ? -a : a;
  endfunction

  function automatic clip_result_t soft_clip(logic signed [15:0] re,
                                            logic signed [15:0] im);
    clip_result_t r;
    longint m2, m, bitv, res, knee, span, d, p, idx, t, lo, hi, nm, thr;
    r.re = re;
    r.im = im;
    r.clipped = 1'b0;
    m2 = longint'(re) * re + longint'(im) * im;
    res = 0;
    bitv = 64'd1 << 40;
    while (bitv > m2) bitv >>= 2;
    while (bitv != 0) begin
      if (m2 >= res + bitv) begin
        m2 -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    m = res;
    thr = thresh_q;
    if (enable_q && thr != 0 && m != 0) begin
      knee = (3 * thr) / 4;
      span = thr - knee;
      if (m > knee) begin
        d = m - knee;
        p = ((d * TANH_DEPTH) << 16) / (4 * span);
        idx = p >> 16;
        if (idx >= TANH_DEPTH) begin
          t = tanh_lut[TANH_DEPTH];
        end else begin
          lo = tanh_lut[idx];
          hi = tanh_lut[idx + 1];
          t = lo + ((((hi >= lo) ? hi - lo : 0) * (p & 16'hFFFF) + 32768) >> 16);
        end
        nm = knee + ((span * t + 16384) >> 15);
        if (nm < m) begin
          r.re = 16'(rescale(re, nm, m));
          r.im = 16'(rescale(im, nm, m));
          r.clipped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // shadow registers, predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    clip_result_t e;
    int           errs;
    errs = 0;
    if (rst) begin
      enable_q   <= 1'b1;
      thresh_q   <= THRESHOLD_RESET;
      fail_count <= 0;
      expected_q.delete();
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CLIP_ENABLE) enable_q <= cfg_data[0];
        else thresh_q <= cfg_data;
      end
      if (in_valid && !in_stall) expected_q.push_back(soft_clip(sample_real, sample_imag));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: re %0d im %0d", out_real, out_imag);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_real !== e.re) begin
            $error("out_real: expected %0d actual %0d", e.re, out_real);
            errs++;
          end
          if (out_imag !== e.im) begin
            $error("out_imag: expected %0d actual %0d", e.im, out_imag);
            errs++;
          end
          if (was_clipped !== e.clipped) begin
            $error("was_clipped: expected %0d actual %0d", e.clipped, was_clipped);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the complex soft clipper
// Walks several threshold and enable settings, each with directed corner
// samples and random bursts aimed around the knee, with random gaps on both
// channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb;
  import csc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_CLIP_ENABLE;
  logic        [15:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample_real = '0;
  logic signed [15:0] sample_imag = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_real;
  logic signed [15:0] out_imag;
  logic               was_clipped;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic               hold_off = 1'b0;
  logic               hold_done = 1'b0;
  logic [15:0]        thresh_now = THRESHOLD_RESET;

  always #2 clk = ~clk;

  complex_soft_clipper uut (.*);

  csc_checker chk (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      if (hold_off && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done <= 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_THRESHOLD) thresh_now = val;
  endtask

  // one sample transfer; gap length chosen by the caller
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    in_valid    <= 1'b1;
    sample_real <= re;
    sample_imag <= im;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one edge first so the count includes the last transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random sample, mostly near the knee region of the current threshold
  task automatic send_random();
    int mag, ang;
    real rad;
    if ($urandom_range(0, 3) == 0) begin
      send_sample(16'($urandom), 16'($urandom));
    end else begin
      mag = $urandom_range(thresh_now * 5 / 8, thresh_now * 2 + 64);
      if (mag > 46340) mag = 46340;
      ang = $urandom_range(0, 3599);
      rad = ang * 3.14159265 / 1800.0;
      send_sample(16'($rtoi(mag * $cos(rad))), 16'($rtoi(mag * $sin(rad))));
    end
  endtask

  // directed corners of the fields and of the clipping path
  task automatic send_corners();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sh8000, 16'sd32767);
    send_sample(16'sd32767, 16'sd0);
    send_sample(16'sd0, 16'sh8000);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'(thresh_now * 3 / 4), 16'sd0);
    send_sample(16'(thresh_now * 3 / 4 + 1), 16'sd0);
    send_sample(16'sd0, 16'(-(thresh_now * 3 / 4 + 2)));
    send_sample(16'(thresh_now), 16'sd0);
    send_sample(16'(-thresh_now), 16'(thresh_now));
    send_sample(16'sd1, 16'sd0);
  endtask

  initial begin
    logic [15:0] settings [8];
    int burst;
    settings = '{16'd16384, 16'd46341, 16'd0, 16'd1, 16'd4, 16'd65535, 16'd30000,
                 16'd2000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_THRESHOLD, settings[ph]);
      write_reg(CFG_CLIP_ENABLE, (ph == 6) ? 16'd0 : 16'd1);
      send_corners();
      for (int i = 0; i < 80; i++) begin
        if (ph == 2 && i == 10) hold_off = 1'b1;
        if (hold_done && hold_off) hold_off = 1'b0;
        burst = $urandom_range(0, 2);
        send_random();
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
        else if (burst == 0 && i == 40 && ph == 4) drain();
      end
      drain();
    end
    wait (!hold_off || hold_done);
    hold_off = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
